// File: hdl/ubrf_pkg.sv
package ubrf_pkg;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [ADDR_W-1:0] SCAN_TOP       = 16'hFFBF;
    localparam logic [ADDR_W-1:0] SCAN_BOTTOM    = 16'h0100;
    localparam logic [ADDR_W-1:0] NOT_FOUND_ADDR = 16'h00FF;
    localparam logic [DATA_W-1:0] FILL_FIRST     = 8'hFF;
    localparam logic [DATA_W-1:0] FILL_LAST      = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LEN   = 2'd2;

    localparam logic [7:0]  RUN_LENGTH_RST = 8'd77;
    localparam logic [15:0] ECHO_START_RST = 16'd0;
    localparam logic [14:0] ECHO_LEN_RST   = 15'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data_byte;
        logic              last_item;
    } in_beat_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start_address;
        logic [DATA_W-1:0] fill_value;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  run_length;
        logic [15:0] echo_start;
        logic [14:0] echo_len;
    } cfg_t;

endpackage

// File: hdl/ubrf_mem.sv
module ubrf_mem
    import ubrf_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ubrf_scan.sv
module ubrf_scan
    import ubrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              start,
    output logic              busy,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_HOLD
    } state_t;

    localparam logic EMPTY_RANGE = (SCAN_TOP < SCAN_BOTTOM);

    state_t            state_reg,  state_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [DATA_W-1:0] val_reg,    val_next;
    logic              issue_reg,  issue_next;
    logic              pv_reg,     pv_next;
    logic [ADDR_W-1:0] paddr_reg,  paddr_next;
    logic [DATA_W-1:0] pval_reg,   pval_next;
    logic              pfirst_reg, pfirst_next;
    logic              plast_reg,  plast_next;
    logic [7:0]        count_reg,  count_next;
    logic [7:0]        need_reg,   need_next;
    logic [ADDR_W:0]   wend_reg,   wend_next;
    out_beat_t         res_reg,    res_next;
    logic              mvalid_reg, mvalid_next;
    out_beat_t         mdata_reg,  mdata_next;

    logic       in_win;
    logic       match;
    logic [7:0] base;
    logic [7:0] base_inc;
    logic       hit;
    out_beat_t  miss;

    assign miss = '{found: 1'b0, start_address: NOT_FOUND_ADDR, fill_value: FILL_LAST};

    always_comb begin
        in_win   = ({1'b0, paddr_reg} >= {1'b0, cfg.echo_start}) &&
                   ({1'b0, paddr_reg} <= wend_reg);
        match    = (rd_data == pval_reg);
        base     = pfirst_reg ? 8'd0 : count_reg;
        base_inc = base + 8'd1;
        hit      = pv_reg && !in_win && match && (base_inc == need_reg);
    end

    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        val_next    = val_reg;
        issue_next  = issue_reg;
        pv_next     = pv_reg;
        paddr_next  = paddr_reg;
        pval_next   = pval_reg;
        pfirst_next = pfirst_reg;
        plast_next  = plast_reg;
        count_next  = count_reg;
        need_next   = need_reg;
        wend_next   = wend_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (start) begin
                    need_next  = (cfg.run_length == 8'd0) ? 8'd1 : cfg.run_length;
                    wend_next  = {1'b0, cfg.echo_start} + {2'b00, cfg.echo_len};
                    addr_next  = SCAN_TOP;
                    val_next   = FILL_FIRST;
                    issue_next = 1'b1;
                    pv_next    = 1'b0;
                    if (EMPTY_RANGE) begin
                        res_next   = miss;
                        issue_next = 1'b0;
                        state_next = ST_HOLD;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read issued at addr_reg returns next cycle; tag it along
                pv_next     = issue_reg;
                paddr_next  = addr_reg;
                pval_next   = val_reg;
                pfirst_next = (addr_reg == SCAN_TOP);
                plast_next  = (addr_reg == SCAN_BOTTOM) && (val_reg == FILL_LAST);
                if (issue_reg) begin
                    if (addr_reg == SCAN_BOTTOM) begin
                        addr_next = SCAN_TOP;
                        val_next  = val_reg - 8'd1;
                        if (val_reg == FILL_LAST) begin
                            issue_next = 1'b0;
                        end
                    end else begin
                        addr_next = addr_reg - 16'd1;
                    end
                end
                if (pv_reg) begin
                    count_next = (!in_win && match) ? base_inc : 8'd0;
                    if (hit || plast_reg) begin
                        if (hit) begin
                            res_next = '{found: 1'b1, start_address: paddr_reg,
                                         fill_value: pval_reg};
                        end else begin
                            res_next = miss;
                        end
                        issue_next = 1'b0;
                        pv_next    = 1'b0;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = res_reg;
                    state_next  = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            issue_reg  <= 1'b0;
            pv_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issue_reg  <= issue_next;
            pv_reg     <= pv_next;
            mvalid_reg <= mvalid_next;
        end
        addr_reg   <= addr_next;
        val_reg    <= val_next;
        paddr_reg  <= paddr_next;
        pval_reg   <= pval_next;
        pfirst_reg <= pfirst_next;
        plast_reg  <= plast_next;
        count_reg  <= count_next;
        need_reg   <= need_next;
        wend_reg   <= wend_next;
        res_reg    <= res_next;
        mdata_reg  <= mdata_next;
    end

    assign busy    = (state_reg != ST_LOAD);
    assign rd_addr = addr_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

endmodule

// File: hdl/uniform_byte_run_finder.sv
// Loads a 64 KiB byte image at one beat per cycle while s_ready is high
// and, on the beat marked last_item, searches it for a run of run_length
// equal bytes, trying fill values 255 down to 0 and scanning 0xFFBF down to
// 0x100 while skipping the echo window [echo_start, echo_start+echo_len].
// The search reads one byte per cycle through the single read port of the
// image memory and ends early at the first qualifying run; s_ready is low
// meanwhile. A result waiting on m_ready in the output register does not
// block further load beats.
module uniform_byte_run_finder
    import ubrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t              cfg_reg;
    logic              busy;
    logic              load_beat;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_length <= RUN_LENGTH_RST;
            cfg_reg.echo_start <= ECHO_START_RST;
            cfg_reg.echo_len   <= ECHO_LEN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RUN_LENGTH: cfg_reg.run_length <= cfg_wdata[7:0];
                CFG_ECHO_START: cfg_reg.echo_start <= cfg_wdata;
                CFG_ECHO_LEN:   cfg_reg.echo_len   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign s_ready   = !busy;
    assign load_beat = s_valid && s_ready;

    ubrf_mem u_mem (
        .aclk    (aclk),
        .wr_en   (load_beat),
        .wr_addr (s_data.address),
        .wr_data (s_data.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ubrf_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .start   (load_beat && s_data.last_item),
        .busy    (busy),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
